// ===== rtl/linear_regression_fit_assert.svh =====
// ---------------------------------------------------------------------------
// linear_regression_fit assertion macros
// Shared concurrent-assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LINEAR_REGRESSION_FIT_ASSERT_SVH
`define LINEAR_REGRESSION_FIT_ASSERT_SVH

// same-cycle implication
`define LRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lrf_pkg.sv =====
// ---------------------------------------------------------------------------
// lrf_pkg
// Shared types and constants of the line-fit block.
// ---------------------------------------------------------------------------
package lrf_pkg;

  // set queue between accumulator and solver
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // solver datapath width
  localparam int WIDE_W = 80;
  localparam int MUL_B_W = 32;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FEW  = 2'd1,
    STAT_FLAT = 2'd2
  } fit_status_t;

  typedef struct packed {
    logic                  empty;
    logic [FIFO_CNT_W-1:0] level;
  } fifo_stat_t;

endpackage

// ===== rtl/linear_regression_fit.sv =====
// ---------------------------------------------------------------------------
// linear_regression_fit
// Streaming least-squares line fit over sets of (x, y) sample pairs.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one pair per transaction, x and y signed Q8.8, in_tlast on the
//           final pair of a set. Taken one per cycle while in_tready is high.
//   out_* : one result per set: slope and intercept in signed Q16.16,
//           saturated, with a status code in out_tuser (0 ok, 1 fewer than
//           two pairs, 2 all x equal; slope and intercept are 0 on error).
// Flow: the accumulator hands a set's sums to a four-deep queue in the
//   cycle after its last pair is taken. The solver then runs five 32-step
//   multiplies and two 80-step divides for an ok set, two multiplies for
//   all-x-equal and none for a short set, then loads the result register.
//   Solver time per set is set by the shared shift-add multiplier and the
//   restoring divider, which retire one bit per cycle.
// Throughput: one pair per cycle while the queue has room; in_tready drops
//   only when queued sets plus a set closing in the product stage reach four.
// Stall: a result waits in the output register while out_tready is low;
//   the solver holds its next result; the front runs on until the queue fills.
// Reset: rst_n (synchronous, active low) clears the sums, the queue and the
//   solver, and drops out_tvalid. Pairs beyond MAX_PAIRS in one set are not
//   summed, but their in_tlast still closes the set.
// ---------------------------------------------------------------------------
module linear_regression_fit #(
  parameter int MAX_PAIRS   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] x_sample, [31:16] y_sample
  input  logic        in_tlast,   // last_pair
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] slope, [63:32] intercept
  output logic [1:0]  out_tuser   // [1:0] status
);

  // pair count and sum widths follow from the set size and sample width
  localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
  localparam int SX_W   = SAMPLE_BITS + CNT_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W;
  localparam int SNAP_W = CNT_W + 2 * SX_W + 2 * SQ_W;

  lrf_pkg::fifo_stat_t q_stat;
  logic                push, pop;
  logic [SNAP_W-1:0]   push_data, head_data;
  logic signed [31:0]  slope, intercept;

  // front: products and running sums, one pair per cycle while there is room
  lrf_front #(
    .MAX_PAIRS   (MAX_PAIRS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .SX_W        (SX_W),
    .SQ_W        (SQ_W),
    .SNAP_W      (SNAP_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .x_in      (in_tdata[15:0]),
    .y_in      (in_tdata[31:16]),
    .last_in   (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // queue of closed sets
  lrf_fifo #(
    .DATA_W (SNAP_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .stat      (q_stat)
  );

  // back: fit equations and result register
  lrf_solve #(
    .CNT_W  (CNT_W),
    .SX_W   (SX_W),
    .SQ_W   (SQ_W),
    .SNAP_W (SNAP_W)
  ) u_solve (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_data (head_data),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .slope     (slope),
    .intercept (intercept),
    .status    (out_tuser)
  );

  assign out_tdata = {intercept, slope};

endmodule

// ===== rtl/lrf_fifo.sv =====
// ---------------------------------------------------------------------------
// lrf_fifo
// Short first-word-fall-through queue of finished set sums.
// ---------------------------------------------------------------------------
`include "linear_regression_fit_assert.svh"

module lrf_fifo #(
  parameter int DATA_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [DATA_W-1:0]   push_data,
  input  logic                pop,
  output logic [DATA_W-1:0]   head_data,
  output lrf_pkg::fifo_stat_t stat
);

  logic [DATA_W-1:0]               mem_r [lrf_pkg::FIFO_DEPTH];
  logic [lrf_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [lrf_pkg::FIFO_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [lrf_pkg::FIFO_CNT_W-1:0]  level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data  = mem_r[rd_ptr_r];
  assign stat.empty = (level_r == '0);
  assign stat.level = level_r;

  `LRF_ASSERT_IMP(a_fifo_no_overflow, push, level_r != lrf_pkg::FIFO_CNT_W'(lrf_pkg::FIFO_DEPTH) || pop, "set queue overflow")
  `LRF_ASSERT_IMP(a_fifo_no_underflow, pop, level_r != '0, "set queue underflow")

endmodule

// ===== rtl/lrf_front.sv =====
// ---------------------------------------------------------------------------
// lrf_front
// Takes sample pairs, squares and multiplies them, keeps the running sums
// and hands a set's totals to the queue on its last pair.
// ---------------------------------------------------------------------------
module lrf_front #(
  parameter int MAX_PAIRS   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 11,
  parameter int SX_W        = 27,
  parameter int SQ_W        = 43,
  parameter int SNAP_W      = 151
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         x_in,
  input  logic [15:0]         y_in,
  input  logic                last_in,
  input  lrf_pkg::fifo_stat_t q_stat,
  output logic                push,
  output logic [SNAP_W-1:0]   push_data
);

  localparam int PROD_W = 2 * SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] xs, ys;

  // product stage
  logic                     s1_valid_r;
  logic                     s1_last_r;
  logic signed [SAMPLE_BITS-1:0] s1_x_r, s1_y_r;
  logic signed [PROD_W-1:0] s1_xx_r, s1_xy_r;

  // running sums
  logic [CNT_W-1:0]       n_r, n_nxt, n_add;
  logic signed [SX_W-1:0] sx_r, sx_nxt, sx_add;
  logic signed [SX_W-1:0] sy_r, sy_nxt, sy_add;
  logic signed [SQ_W-1:0] sxy_r, sxy_nxt, sxy_add;
  logic signed [SQ_W-1:0] sx2_r, sx2_nxt, sx2_add;

  logic accept;
  logic room;

  assign xs = SAMPLE_BITS'(x_in);
  assign ys = SAMPLE_BITS'(y_in);

  // keep a slot for the set in the product stage and one for the new pair
  assign room = ({1'b0, q_stat.level} + (lrf_pkg::FIFO_CNT_W + 1)'(s1_valid_r & s1_last_r))
                < (lrf_pkg::FIFO_CNT_W + 1)'(lrf_pkg::FIFO_DEPTH);
  assign in_ready = room;
  assign accept   = in_valid && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r <= last_in;
      s1_x_r    <= xs;
      s1_y_r    <= ys;
      s1_xx_r   <= xs * xs;
      s1_xy_r   <= xs * ys;
    end
  end

  always_comb begin
    n_add   = n_r;
    sx_add  = sx_r;
    sy_add  = sy_r;
    sxy_add = sxy_r;
    sx2_add = sx2_r;
    if (n_r < CNT_W'(MAX_PAIRS)) begin
      n_add   = n_r + 1'b1;
      sx_add  = sx_r + SX_W'(s1_x_r);
      sy_add  = sy_r + SX_W'(s1_y_r);
      sxy_add = sxy_r + SQ_W'(s1_xy_r);
      sx2_add = sx2_r + SQ_W'(s1_xx_r);
    end

    n_nxt   = n_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    sxy_nxt = sxy_r;
    sx2_nxt = sx2_r;
    if (s1_valid_r) begin
      if (s1_last_r) begin
        n_nxt   = '0;
        sx_nxt  = '0;
        sy_nxt  = '0;
        sxy_nxt = '0;
        sx2_nxt = '0;
      end else begin
        n_nxt   = n_add;
        sx_nxt  = sx_add;
        sy_nxt  = sy_add;
        sxy_nxt = sxy_add;
        sx2_nxt = sx2_add;
      end
    end
  end

  assign push      = s1_valid_r && s1_last_r;
  assign push_data = {sx2_add, sxy_add, sy_add, sx_add, n_add};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxy_r <= '0;
      sx2_r <= '0;
    end else begin
      n_r   <= n_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sxy_r <= sxy_nxt;
      sx2_r <= sx2_nxt;
    end
  end

endmodule

// ===== rtl/lrf_solve.sv =====
// ---------------------------------------------------------------------------
// lrf_solve
// Sequential solver: shift-add multiplier and restoring divider shared over
// the fit equations, with the result register.
// ---------------------------------------------------------------------------
`include "linear_regression_fit_assert.svh"

module lrf_solve #(
  parameter int CNT_W  = 11,
  parameter int SX_W   = 27,
  parameter int SQ_W   = 43,
  parameter int SNAP_W = 151
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lrf_pkg::fifo_stat_t q_stat,
  input  logic [SNAP_W-1:0]   head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  slope,
  output logic signed [31:0]  intercept,
  output logic [1:0]          status
);

  localparam int W = lrf_pkg::WIDE_W;
  localparam int BW = lrf_pkg::MUL_B_W;
  localparam int STEP_W = $clog2(W);
  localparam int MUL_STEPS = BW;
  localparam int DIV_STEPS = W;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_M_NSX2 = 9'b000000010,
    ST_M_SXSX = 9'b000000100,
    ST_M_NSXY = 9'b000001000,
    ST_M_SXSY = 9'b000010000,
    ST_D_SLP  = 9'b000100000,
    ST_M_SLSX = 9'b001000000,
    ST_D_ICP  = 9'b010000000,
    ST_OUT    = 9'b100000000
  } solve_state_t;

  function automatic logic signed [31:0] sat_q(input logic [W-1:0] q, input logic neg);
    logic [W-1:0] lim;
    logic [W-1:0] qs;
    lim = neg ? W'(33'h0_8000_0000) : W'(33'h0_7FFF_FFFF);
    qs  = (q > lim) ? lim : q;
    return neg ? 32'(-qs) : qs[31:0];
  endfunction

  solve_state_t state_r, state_nxt;

  // set sums
  logic [CNT_W-1:0]       n_r, n_nxt, h_n;
  logic signed [SX_W-1:0] sx_r, sx_nxt, h_sx;
  logic signed [SX_W-1:0] sy_r, sy_nxt, h_sy;
  logic signed [SQ_W-1:0] sxy_r, sxy_nxt, h_sxy;
  logic signed [SQ_W-1:0] h_sx2;

  // engines
  logic signed [W-1:0]  acc_r, acc_nxt, acc_step, addend;
  logic signed [W-1:0]  ash_r, ash_nxt;
  logic [BW-1:0]        b_r, b_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [W-1:0]         dv_r, dv_nxt, dv_step;
  logic [W-1:0]         rem_r, rem_nxt, rem_sh;
  logic [W-1:0]         dsor_r, dsor_nxt;
  logic                 neg_r, neg_nxt;
  logic                 mul_last, div_last, ge;

  // intermediates and results
  logic signed [W-1:0]  t_r, t_nxt;
  logic signed [W-1:0]  diff;
  logic [W-1:0]         mag;
  logic signed [31:0]   slope_r, slope_nxt, sat_val;
  logic signed [31:0]   icpt_r, icpt_nxt;
  lrf_pkg::fit_status_t stat_r, stat_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic signed [31:0]   out_slope_r, out_icpt_r;
  logic [1:0]           out_stat_r;
  logic                 load;

  assign {h_sx2, h_sxy, h_sy, h_sx, h_n} = head_data;

  always_comb begin
    mul_last = (step_r == STEP_W'(MUL_STEPS - 1));
    div_last = (step_r == STEP_W'(DIV_STEPS - 1));
    addend   = b_r[0] ? (mul_last ? -ash_r : ash_r) : '0;
    acc_step = acc_r + addend;
    rem_sh   = {rem_r[W-2:0], dv_r[W-1]};
    ge       = (rem_sh >= dsor_r);
    dv_step  = {dv_r[W-2:0], ge};
    sat_val  = sat_q(dv_step, neg_r);
    diff     = '0;
    mag      = '0;

    state_nxt = state_r;
    n_nxt     = n_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    sxy_nxt   = sxy_r;
    acc_nxt   = acc_step;
    ash_nxt   = ash_r <<< 1;
    b_nxt     = b_r >> 1;
    step_nxt  = step_r + 1'b1;
    dv_nxt    = dv_step;
    rem_nxt   = ge ? rem_sh - dsor_r : rem_sh;
    dsor_nxt  = dsor_r;
    neg_nxt   = neg_r;
    t_nxt     = t_r;
    slope_nxt = slope_r;
    icpt_nxt  = icpt_r;
    stat_nxt  = stat_r;
    pop       = 1'b0;
    load      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (!q_stat.empty) begin
          pop     = 1'b1;
          n_nxt   = h_n;
          sx_nxt  = h_sx;
          sy_nxt  = h_sy;
          sxy_nxt = h_sxy;
          if (h_n < CNT_W'(2)) begin
            stat_nxt  = lrf_pkg::STAT_FEW;
            slope_nxt = '0;
            icpt_nxt  = '0;
            state_nxt = ST_OUT;
          end else begin
            acc_nxt   = '0;
            ash_nxt   = W'(h_sx2);
            b_nxt     = BW'(h_n);
            state_nxt = ST_M_NSX2;
          end
        end
      end
      ST_M_NSX2: begin
        if (mul_last) begin
          t_nxt     = acc_step;
          acc_nxt   = '0;
          ash_nxt   = W'(sx_r);
          b_nxt     = BW'(sx_r);
          step_nxt  = '0;
          state_nxt = ST_M_SXSX;
        end
      end
      ST_M_SXSX: begin
        if (mul_last) begin
          diff     = t_r - acc_step;
          step_nxt = '0;
          if (diff[W-1] || diff == '0) begin
            stat_nxt  = lrf_pkg::STAT_FLAT;
            slope_nxt = '0;
            icpt_nxt  = '0;
            state_nxt = ST_OUT;
          end else begin
            dsor_nxt  = diff;
            acc_nxt   = '0;
            ash_nxt   = W'(sxy_r);
            b_nxt     = BW'(n_r);
            state_nxt = ST_M_NSXY;
          end
        end
      end
      ST_M_NSXY: begin
        if (mul_last) begin
          t_nxt     = acc_step;
          acc_nxt   = '0;
          ash_nxt   = W'(sx_r);
          b_nxt     = BW'(sy_r);
          step_nxt  = '0;
          state_nxt = ST_M_SXSY;
        end
      end
      ST_M_SXSY: begin
        if (mul_last) begin
          diff      = t_r - acc_step;
          mag       = diff[W-1] ? W'(-diff) : W'(diff);
          neg_nxt   = diff[W-1];
          dv_nxt    = mag << 16;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_D_SLP;
        end
      end
      ST_D_SLP: begin
        if (div_last) begin
          slope_nxt = sat_val;
          acc_nxt   = '0;
          ash_nxt   = W'(sx_r);
          b_nxt     = BW'(sat_val);
          step_nxt  = '0;
          state_nxt = ST_M_SLSX;
        end
      end
      ST_M_SLSX: begin
        if (mul_last) begin
          // intercept numerator in units of 2^-24
          diff      = (W'(sy_r) <<< 16) - acc_step;
          mag       = diff[W-1] ? W'(-diff) : W'(diff);
          neg_nxt   = diff[W-1];
          dv_nxt    = mag;
          rem_nxt   = '0;
          dsor_nxt  = W'(n_r) << 8;
          step_nxt  = '0;
          state_nxt = ST_D_ICP;
        end
      end
      ST_D_ICP: begin
        if (div_last) begin
          icpt_nxt  = sat_val;
          stat_nxt  = lrf_pkg::STAT_OK;
          step_nxt  = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        step_nxt = '0;
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    sxy_r   <= sxy_nxt;
    acc_r   <= acc_nxt;
    ash_r   <= ash_nxt;
    b_r     <= b_nxt;
    dv_r    <= dv_nxt;
    rem_r   <= rem_nxt;
    dsor_r  <= dsor_nxt;
    neg_r   <= neg_nxt;
    t_r     <= t_nxt;
    slope_r <= slope_nxt;
    icpt_r  <= icpt_nxt;
    stat_r  <= stat_nxt;
    if (load) begin
      out_slope_r <= slope_r;
      out_icpt_r  <= icpt_r;
      out_stat_r  <= stat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign slope     = out_slope_r;
  assign intercept = out_icpt_r;
  assign status    = out_stat_r;

  `LRF_ASSERT_IMP(a_pop_only_idle, pop, state_r == ST_IDLE, "set taken while solver busy")
  `LRF_ASSERT_IMP(a_div_nonzero, state_r == ST_D_SLP || state_r == ST_D_ICP, dsor_r != '0, "divide by zero")
  `LRF_ASSERT_NXT(a_load_valid, load, out_valid_r, "result load lost")

endmodule

// ===== dv/linear_regression_fit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_regression_fit_test
// Self-checking bench for the streaming line fit. Pairs go in on the in_*
// stream. A scoreboard model keeps its own count and sums, and solves each
// set on its last pair. Every out_* transaction is compared field by field
// with the oldest pending fit. A short directed table runs first, then
// random sets of mixed shapes. Both streams idle and stall at random.
// ---------------------------------------------------------------------------
module linear_regression_fit_test;

  localparam int MAX_PAIRS    = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int RAND_PAIRS   = 1030;     // pairs in the random sets, at least
  localparam int MIN_SETS     = 40;       // random sets, at least
  localparam int DRAIN_CYCLES = 400;      // idle time after the last result, for stray results
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [31:0]          slope;
    logic [31:0]          icpt;
    lrf_pkg::fit_status_t status;
  } line_fit_t;

  // one row of the directed table; fit holds a typed-in result when typed is set
  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    bit          typed;
    line_fit_t   fit;
  } pair_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [15:0] x_sample, [31:16] y_sample
  logic        in_tlast   = 1'b0; // last_pair
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // [31:0] slope, [63:32] intercept
  logic [1:0]  out_tuser;         // [1:0] status

  // scoreboard model state: count and running sums of the open set
  int        acc_count;
  longint    acc_x;
  longint    acc_y;
  longint    acc_xy;
  longint    acc_x2;

  line_fit_t pending_fits[$];
  pair_row_t directed_pairs[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  bit        in_calm = 1'b0;      // no input gaps for the current set
  bit        out_calm = 1'b0;     // no output stalls for a stretch
  int        stall_left = 0;

  linear_regression_fit #(
    .MAX_PAIRS  (MAX_PAIRS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = int'($urandom_range(99));
    if (r < 65) return 0;
    if (r < 90) return int'($urandom_range(3, 1));
    if (r < 98) return int'($urandom_range(12, 4));
    return int'($urandom_range(60, 20));
  endfunction

  // num / den with frac_bits extra fraction bits, truncated toward zero,
  // clamped to the signed 32-bit range. Long division, one bit per step,
  // stops as soon as the quotient passes the clamp.
  function automatic longint fit_divide(input longint num, input longint unsigned den,
                                        input int frac_bits);
    bit              neg;
    bit              sat;
    longint unsigned mag;
    longint unsigned quo;
    longint unsigned rem;
    longint unsigned lim;
    neg = (num < 0);
    mag = neg ? longint'(-num) : num;
    quo = mag / den;
    rem = mag % den;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    sat = (quo > lim);
    for (int i = 0; i < frac_bits && !sat; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
      if (quo > lim) sat = 1'b1;
    end
    if (sat) quo = lim;
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  // Fold one accepted pair into the sums; on the last pair solve the set
  // and clear. Pairs past MAX_PAIRS are dropped, but still close a set.
  task automatic sum_pair_and_fit(input logic [15:0] x_raw, input logic [15:0] y_raw,
                                  input logic last, output bit done,
                                  output line_fit_t fit);
    longint x;
    longint y;
    longint n;
    longint den;
    longint num;
    longint inum;
    longint slope;
    longint icpt;
    x          = longint'($signed(x_raw));
    y          = longint'($signed(y_raw));
    done       = 1'b0;
    slope      = 0;
    icpt       = 0;
    fit.status = lrf_pkg::STAT_OK;
    if (acc_count < MAX_PAIRS) begin
      acc_count++;
      acc_x  += x;
      acc_y  += y;
      acc_xy += x * y;
      acc_x2 += x * x;
    end
    if (last) begin
      done = 1'b1;
      if (acc_count < 2) begin
        fit.status = lrf_pkg::STAT_FEW;
      end else begin
        n   = longint'(acc_count);
        den = n * acc_x2 - acc_x * acc_x;
        if (den <= 0) begin
          fit.status = lrf_pkg::STAT_FLAT;
        end else begin
          num   = n * acc_xy - acc_x * acc_y;
          slope = fit_divide(num, longint'(den), 16);
          // Sy moved to 2^-24 units; slope (2^-16) times Sx (2^-8) is already there
          inum  = acc_y * 65536 - slope * acc_x;
          icpt  = fit_divide(inum, longint'(n * 256), 0);
        end
      end
      fit.slope = slope[31:0];
      fit.icpt  = icpt[31:0];
      acc_count = 0;
      acc_x     = 0;
      acc_y     = 0;
      acc_xy    = 0;
      acc_x2    = 0;
    end
  endtask

  task automatic add_row(input int x, input int y, input bit last, input bit typed,
                         input int slope, input int icpt,
                         input lrf_pkg::fit_status_t status);
    pair_row_t row;
    row.x          = 16'(x);
    row.y          = 16'(y);
    row.last       = last;
    row.typed      = typed;
    row.fit.slope  = 32'(slope);
    row.fit.icpt   = 32'(icpt);
    row.fit.status = status;
    directed_pairs.push_back(row);
  endtask

  // One input transaction: optional idle gap, then hold valid until taken.
  // The pending fit is queued at the accepting edge.
  task automatic drive_pair(input logic [15:0] x, input logic [15:0] y, input logic last,
                            input bit typed, input line_fit_t typed_fit);
    int        gap;
    bit        done;
    line_fit_t fit;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sum_pair_and_fit(x, y, last, done, fit);
    if (done) pending_fits.push_back(typed ? typed_fit : fit);
  endtask

  // Output side: random stalls on out_tready, scoreboard compare on each
  // out_* transaction.
  always @(posedge clk) begin
    line_fit_t exp_fit;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_fits.size() == 0) begin
        $display("%0t: unexpected result, expected none, got slope %h icpt %h status %0d",
                 $time, out_tdata[31:0], out_tdata[63:32], out_tuser);
        fail_count++;
      end else begin
        exp_fit = pending_fits.pop_front();
        if (out_tdata[31:0] !== exp_fit.slope) begin
          $display("%0t: slope mismatch, expected %h, got %h",
                   $time, exp_fit.slope, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[63:32] !== exp_fit.icpt) begin
          $display("%0t: intercept mismatch, expected %h, got %h",
                   $time, exp_fit.icpt, out_tdata[63:32]);
          fail_count++;
        end
        if (out_tuser !== exp_fit.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, exp_fit.status, out_tuser);
          fail_count++;
        end
      end
    end
    // now and then switch between stalling and stall-free stretches
    if ($urandom_range(499) == 0) out_calm <= ~out_calm;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!out_calm && $urandom_range(99) < 20) stall_left <= pick_gap(1'b0);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int          set_len;
    int          kind;
    int          r;
    int          rand_pairs;
    int          sets_done;
    int          xs;
    int          gain;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] base_x;
    line_fit_t   no_fit;

    acc_count  = 0;
    acc_x      = 0;
    acc_y      = 0;
    acc_xy     = 0;
    acc_x2     = 0;
    rand_pairs = 0;
    sets_done  = 0;
    no_fit     = '{slope: '0, icpt: '0, status: lrf_pkg::STAT_OK};

    // Directed table. Typed rows carry results read straight off the math;
    // the rest go through the scoreboard model.
    // single-pair sets at the sample extremes: too few points
    add_row(-32768,  32767, 1, 1, 0, 0, lrf_pkg::STAT_FEW);
    add_row( 32767, -32768, 1, 1, 0, 0, lrf_pkg::STAT_FEW);
    // all x equal at the top, y at both extremes: zero denominator
    add_row( 32767,      0, 0, 0, 0, 0, lrf_pkg::STAT_OK);
    add_row( 32767,  32767, 0, 0, 0, 0, lrf_pkg::STAT_OK);
    add_row( 32767, -32768, 1, 1, 0, 0, lrf_pkg::STAT_FLAT);
    // all x equal at the bottom
    add_row(-32768, -32768, 0, 0, 0, 0, lrf_pkg::STAT_OK);
    add_row(-32768,  32767, 1, 1, 0, 0, lrf_pkg::STAT_FLAT);
    // y = x: slope 1.0, intercept 0
    add_row(     0,      0, 0, 0, 0, 0, lrf_pkg::STAT_OK);
    add_row(   256,    256, 1, 1, 32'h0001_0000, 0, lrf_pkg::STAT_OK);
    // one-lsb x step, full y swing: slope clamps high
    add_row(     0, -32768, 0, 0, 0, 0, lrf_pkg::STAT_OK);
    add_row(     1,  32767, 1, 0, 0, 0, lrf_pkg::STAT_OK);
    // same at the top of x, falling: slope clamps low, intercept clamps from it
    add_row( 32767, -32768, 0, 0, 0, 0, lrf_pkg::STAT_OK);
    add_row( 32766,  32767, 1, 0, 0, 0, lrf_pkg::STAT_OK);
    // corners mixed
    add_row(-32768, -32768, 0, 0, 0, 0, lrf_pkg::STAT_OK);
    add_row( 32767,  32767, 0, 0, 0, 0, lrf_pkg::STAT_OK);
    add_row(    -1,      0, 0, 0, 0, 0, lrf_pkg::STAT_OK);
    add_row(     1,     -1, 1, 0, 0, 0, lrf_pkg::STAT_OK);
    // y = -2x: slope -2.0, intercept 0
    add_row(  -256,    512, 0, 0, 0, 0, lrf_pkg::STAT_OK);
    add_row(   256,   -512, 0, 0, 0, 0, lrf_pkg::STAT_OK);
    add_row(   768,  -1536, 1, 1, -131072, 0, lrf_pkg::STAT_OK);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_pairs[i])
      drive_pair(directed_pairs[i].x, directed_pairs[i].y, directed_pairs[i].last,
                 directed_pairs[i].typed, directed_pairs[i].fit);

    // Random sets. Shapes: free x/y, x in a 4-lsb band (steep, clamping),
    // one x for the whole set, and y near a line through x.
    while (rand_pairs < RAND_PAIRS || sets_done < MIN_SETS) begin
      r = int'($urandom_range(99));
      if (r < 5)       set_len = 1;
      else if (r < 70) set_len = int'($urandom_range(12, 2));
      else if (r < 95) set_len = int'($urandom_range(40, 13));
      else             set_len = int'($urandom_range(200, 41));
      kind    = int'($urandom_range(3));
      in_calm = ($urandom_range(4) == 0);
      base_x  = 16'($urandom);
      gain    = int'($urandom_range(1023)) - 512;
      for (int k = 0; k < set_len; k++) begin
        case (kind)
          0: begin
            x = 16'($urandom);
            y = 16'($urandom);
          end
          1: begin
            x = base_x + 16'($urandom_range(3));
            y = 16'($urandom);
          end
          2: begin
            x = base_x;
            y = 16'($urandom);
          end
          default: begin
            x  = 16'($urandom);
            xs = int'($signed(x));
            y  = 16'(((xs * gain) >>> 8) + int'($urandom_range(63)) - 32);
          end
        endcase
        drive_pair(x, y, (k == set_len - 1), 1'b0, no_fit);
      end
      rand_pairs += set_len;
      sets_done++;
    end

    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // drain, then give stray results a chance to show up
    while (pending_fits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
